// ----- sv/bss_pkg.sv -----
// Shared types, constants and helpers for the bounded substring search.
// Used by bss_cell, bss_tracker and bounded_substring_search; no dependencies.
package bss_pkg;

	// Field and register widths.
	localparam int BYTE_W        = 8;
	localparam int NEEDLE_W      = 64;
	localparam int LEN_W         = 5;
	localparam int OFFSET_W      = 16;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 3;
	localparam int S_TDATA_W     = 8;
	localparam int M_TDATA_W     = 24;

	// Needle storage and defaults for the top-level parameters.
	localparam int NEEDLE_BYTES      = 16;
	localparam int DEF_MAX_NEEDLE    = 16;
	localparam int DEF_OFFSET_BITS   = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 3'd4;

	// Search direction codes.
	localparam logic DIR_FIRST = 1'b0;
	localparam logic DIR_LAST  = 1'b1;

	// ASCII upper-case range.
	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

	typedef logic [BYTE_W-1:0] byte_t;

	// Per-beat control handed from the cell row to the tracker.
	typedef struct packed {
		logic beat;
		logic last;
		logic window_hit;
	} bss_beat_t;

	// Result handed from the tracker to the output register.
	typedef struct packed {
		logic                valid;
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} bss_result_t;

	// Folds upper-case ASCII letters to lower case when folding is enabled.
	function automatic byte_t fold_byte(input logic fold, input byte_t b);
		byte_t r;
		r = b;
		if (fold && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
			r = b + ASCII_CASE_OFS;
		end
		return r;
	endfunction

endpackage

// ----- sv/bss_cell.sv -----
// One cell of the haystack window: holds one byte and compares the byte entering it with its needle byte.
// Depends on bss_pkg.
module bss_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   beat,
	input  bss_pkg::byte_t         byte_in,
	input  bss_pkg::byte_t         needle [bss_pkg::NEEDLE_BYTES],
	input  logic [bss_pkg::LEN_W-1:0] len,
	input  logic                   fold,
	output bss_pkg::byte_t         byte_q,
	output logic                   hit
);
	import bss_pkg::*;

	localparam int IDX_W = $clog2(NEEDLE_BYTES);
	localparam logic [LEN_W-1:0] POS = LEN_W'(CELL_INDEX);

	logic [LEN_W-1:0] needle_pos;
	logic [IDX_W-1:0] needle_idx;

	// The byte shifts in from the neighbour on every beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (beat) begin
			byte_q <= byte_in;
		end
	end

	// The newest byte lines up with the last needle byte in use.
	assign needle_pos = len - POS - LEN_W'(1);
	assign needle_idx = needle_pos[IDX_W-1:0];

	// Compare the byte entering this cell; cells beyond the needle always agree.
	assign hit = (POS >= len) ||
		(fold_byte(fold, byte_in) == fold_byte(fold, needle[needle_idx]));

endmodule

// ----- sv/bss_tracker.sv -----
// Stream position counter and match record for the bounded substring search.
// Depends on bss_pkg.
module bss_tracker #(
	parameter int OFFSET_BITS = bss_pkg::DEF_OFFSET_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bss_pkg::bss_beat_t        beat_info,
	input  logic [bss_pkg::LEN_W-1:0] len,
	input  logic                      direction,
	output bss_pkg::bss_result_t      result
);
	import bss_pkg::*;

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	logic [OFFSET_BITS-1:0] count_q;
	logic                   match_q;
	logic [OFFSET_BITS-1:0] held_q;
	logic [OFFSET_BITS-1:0] count_next;
	logic [OFFSET_BITS-1:0] len_ext;
	logic                   record;
	logic                   match_next;
	logic [OFFSET_BITS-1:0] held_next;

	// Saturating byte count including the current beat.
	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + OFFSET_BITS'(1);
	assign len_ext    = OFFSET_BITS'(len);

	// A full window match is recorded once in first mode, every time in last mode.
	assign record = beat_info.window_hit && (len != '0) && (count_next >= len_ext) &&
		((direction == DIR_LAST) || !match_q);
	assign match_next = match_q || record;
	assign held_next  = !record ? held_q :
		(count_next == COUNT_MAX) ? COUNT_MAX : count_next - len_ext;

	// Stream state; cleared after the final beat of each haystack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			match_q <= 1'b0;
			held_q  <= '0;
		end else if (beat_info.beat) begin
			if (beat_info.last) begin
				count_q <= '0;
				match_q <= 1'b0;
				held_q  <= '0;
			end else begin
				count_q <= count_next;
				match_q <= match_next;
				held_q  <= held_next;
			end
		end
	end

	// Result for the final beat; an empty needle always matches.
	always_comb begin
		result.valid  = beat_info.beat && beat_info.last;
		result.found  = 1'b0;
		result.offset = '0;
		if (len == '0) begin
			result.found  = 1'b1;
			result.offset = (direction == DIR_LAST) ? OFFSET_W'(count_next) : '0;
		end else if (match_next) begin
			result.found  = 1'b1;
			result.offset = OFFSET_W'(held_next);
		end
	end

endmodule

// ----- sv/bounded_substring_search.sv -----
// Top level of the bounded substring search: configuration registers, window cell row
// and output register. Depends on bss_pkg, bss_cell and bss_tracker.
//
//  Channel  Direction  Payload
//  s_*      in         tdata[7:0] haystack_byte, tlast final_byte
//  m_*      out        tdata[0] found, tdata[16:1] match_offset, tdata[23:17] zero
//  cfg_*    in         cfg_index selects register, cfg_data holds its value
//
// One haystack byte is taken every cycle while s_tready is high; the window compare across
// all cells is done in the cycle the beat is accepted, and the result of a final byte sits
// in the output register from the next cycle.
// Reset clears configuration, stream state and the output register.
// While a result waits on m_tready the input still accepts, unless a second final byte
// would overwrite it; then s_tready drops until the result is taken.
module bounded_substring_search #(
	parameter int MAX_NEEDLE  = bss_pkg::DEF_MAX_NEEDLE,
	parameter int OFFSET_BITS = bss_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bss_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] haystack_byte
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bss_pkg::M_TDATA_W-1:0]   m_tdata,  // [0] found, [16:1] match_offset
	input  logic                            cfg_we,
	input  logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bss_pkg::*;

	logic [NEEDLE_W-1:0] needle_low_q;
	logic [NEEDLE_W-1:0] needle_high_q;
	logic [LEN_W-1:0]    pattern_len_q;
	logic                fold_q;
	logic                direction_q;

	byte_t               needle [NEEDLE_BYTES];
	logic [LEN_W-1:0]    len_used;
	byte_t               window [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] cell_hit;
	logic                beat;
	bss_beat_t           beat_info;
	bss_result_t         result;

	logic                out_valid_q;
	logic                out_found_q;
	logic [OFFSET_W-1:0] out_offset_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_low_q  <= '0;
			needle_high_q <= '0;
			pattern_len_q <= '0;
			fold_q        <= 1'b0;
			direction_q   <= DIR_FIRST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEEDLE_LOW:  needle_low_q  <= cfg_data;
				REG_NEEDLE_HIGH: needle_high_q <= cfg_data;
				REG_NEEDLE_LEN:  pattern_len_q <= cfg_data[LEN_W-1:0];
				REG_CASE_FOLD:   fold_q        <= cfg_data[0];
				REG_DIRECTION:   direction_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Needle bytes in order, byte 0 first.
	always_comb begin
		for (int k = 0; k < NEEDLE_BYTES / 2; k++) begin
			needle[k]                    = needle_low_q[k*BYTE_W +: BYTE_W];
			needle[k + NEEDLE_BYTES / 2] = needle_high_q[k*BYTE_W +: BYTE_W];
		end
	end

	// Lengths beyond the window are clamped to the window depth.
	assign len_used = (pattern_len_q > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : pattern_len_q;

	// The output register frees itself when taken; a result stays until then.
	assign s_tready = !out_valid_q || m_tready || !s_tlast;
	assign beat     = s_tvalid && s_tready;

	// Row of window cells, newest byte in cell 0.
	for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
		byte_t cell_in;
		if (j == 0) begin : g_head
			assign cell_in = s_tdata[BYTE_W-1:0];
		end else begin : g_link
			assign cell_in = window[j-1];
		end
		bss_cell #(
			.CELL_INDEX(j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.beat    (beat),
			.byte_in (cell_in),
			.needle  (needle),
			.len     (len_used),
			.fold    (fold_q),
			.byte_q  (window[j]),
			.hit     (cell_hit[j])
		);
	end

	assign beat_info.beat       = beat;
	assign beat_info.last       = s_tlast;
	assign beat_info.window_hit = &cell_hit;

	bss_tracker #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_info (beat_info),
		.len       (len_used),
		.direction (direction_q),
		.result    (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_found_q  <= 1'b0;
			out_offset_q <= '0;
		end else if (result.valid) begin
			out_found_q  <= result.found;
			out_offset_q <= result.offset;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - OFFSET_W - 1)'(0), out_offset_q, out_found_q};

endmodule
